// File: hdl/b2a_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package b2a_pkg;

    // Fixed width of the value field on the port.
    localparam int FIELD_W  = 64;
    // Digit storage sized for the widest value: 20 decimal digits.
    localparam int DIG_MAX  = 20;
    localparam int CNT_W    = 5;
    localparam int CHAR_W   = 7;

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
    localparam logic [CHAR_W-1:0] CHAR_X     = 7'h78;
    localparam logic [CHAR_W-1:0] ALPHA_OFS  = 7'h57;
    localparam logic [3:0]        NIB_MAX    = 4'hf;
    localparam logic [3:0]        DEC_TOP    = 4'd9;

    typedef logic [DIG_MAX-1:0][3:0] t_digits;

    // One queued job: format, digit count, digits (LSD at index 0).
    typedef struct packed {
        logic             hex;
        logic [CNT_W-1:0] cnt;
        t_digits          digits;
    } t_entry;

    typedef struct packed {
        logic full;
        logic empty;
    } t_fifo_stat;

    typedef enum logic [1:0] {
        FS_IDLE,
        FS_CONV,
        FS_PUSH
    } t_front_state;

    function automatic logic [CHAR_W-1:0] nib_to_char(input logic [3:0] nib);
        logic [CHAR_W-1:0] wide;
        wide = {3'b000, nib & NIB_MAX};
        if (nib > DEC_TOP) begin
            return wide + ALPHA_OFS;
        end
        return wide + CHAR_ZERO;
    endfunction

endpackage

`default_nettype wire

// File: hdl/b2a_front.sv
`timescale 1ns / 1ps
`default_nettype none

module b2a_front #(
    parameter int VALUE_WIDTH = 64
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_start,
    input  wire logic                    i_func,
    input  wire logic [VALUE_WIDTH-1:0]  i_value,
    output logic                         o_busy,
    output logic                         o_push,
    output b2a_pkg::t_entry              o_entry,
    input  wire b2a_pkg::t_fifo_stat     i_stat
);

    localparam int HEX_DIGITS = (VALUE_WIDTH + 3) / 4;
    localparam int ITER_W     = (VALUE_WIDTH > 1) ? $clog2(VALUE_WIDTH) : 1;
    localparam int BCD_W      = b2a_pkg::DIG_MAX * 4;

    b2a_pkg::t_front_state r_state, n_state;
    logic [VALUE_WIDTH-1:0] r_shift, n_shift;
    b2a_pkg::t_digits       r_bcd, n_bcd;
    logic [ITER_W-1:0]      r_iter, n_iter;
    logic                   r_hex, n_hex;

    b2a_pkg::t_digits              w_adj;
    logic [BCD_W-1:0]              w_adj_flat;
    logic [b2a_pkg::CNT_W-1:0]     w_sig;

    // add-3 correction on every BCD digit before the shift
    always_comb begin
        for (int i = 0; i < b2a_pkg::DIG_MAX; i++) begin
            w_adj[i] = (r_bcd[i] > 4'd4) ? r_bcd[i] + 4'd3 : r_bcd[i];
        end
    end

    assign w_adj_flat = w_adj;

    // number of significant decimal digits, at least one
    always_comb begin
        w_sig = b2a_pkg::CNT_W'(1);
        for (int i = 0; i < b2a_pkg::DIG_MAX; i++) begin
            if (r_bcd[i] != 4'd0) begin
                w_sig = b2a_pkg::CNT_W'(i + 1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= b2a_pkg::FS_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_shift <= n_shift;
        r_bcd   <= n_bcd;
        r_iter  <= n_iter;
        r_hex   <= n_hex;
    end

    always_comb begin
        n_state = r_state;
        n_shift = r_shift;
        n_bcd   = r_bcd;
        n_iter  = r_iter;
        n_hex   = r_hex;
        o_push  = 1'b0;
        case (r_state)
            b2a_pkg::FS_IDLE: begin
                if (i_start) begin
                    n_hex  = i_func;
                    n_iter = '0;
                    if (i_func) begin
                        n_bcd   = b2a_pkg::t_digits'(BCD_W'(i_value));
                        n_state = b2a_pkg::FS_PUSH;
                    end else begin
                        n_bcd   = '0;
                        n_shift = i_value;
                        n_state = b2a_pkg::FS_CONV;
                    end
                end
            end
            b2a_pkg::FS_CONV: begin
                n_bcd   = b2a_pkg::t_digits'({w_adj_flat[BCD_W-2:0],
                                              r_shift[VALUE_WIDTH-1]});
                n_shift = r_shift << 1;
                n_iter  = r_iter + ITER_W'(1);
                if (r_iter == ITER_W'(VALUE_WIDTH - 1)) begin
                    n_state = b2a_pkg::FS_PUSH;
                end
            end
            b2a_pkg::FS_PUSH: begin
                if (!i_stat.full) begin
                    o_push  = 1'b1;
                    n_state = b2a_pkg::FS_IDLE;
                end
            end
            default: begin
                n_state = b2a_pkg::FS_IDLE;
            end
        endcase
    end

    assign o_busy         = (r_state != b2a_pkg::FS_IDLE);
    assign o_entry.hex    = r_hex;
    assign o_entry.cnt    = r_hex ? b2a_pkg::CNT_W'(HEX_DIGITS) : w_sig;
    assign o_entry.digits = r_bcd;

endmodule

`default_nettype wire

// File: hdl/b2a_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module b2a_fifo (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_push,
    input  wire b2a_pkg::t_entry     i_entry,
    input  wire logic                i_pop,
    output b2a_pkg::t_entry          o_entry,
    output b2a_pkg::t_fifo_stat      o_stat
);

    b2a_pkg::t_entry r_mem [2];
    logic            r_wp, n_wp;
    logic            r_rp, n_rp;
    logic [1:0]      r_count, n_count;

    always_comb begin
        n_wp    = r_wp ^ i_push;
        n_rp    = r_rp ^ i_pop;
        n_count = r_count + 2'(i_push) - 2'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= 1'b0;
            r_rp    <= 1'b0;
            r_count <= '0;
        end else begin
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_count <= n_count;
        end
        if (i_push) begin
            r_mem[r_wp] <= i_entry;
        end
    end

    assign o_entry      = r_mem[r_rp];
    assign o_stat.full  = (r_count == 2'd2);
    assign o_stat.empty = (r_count == 2'd0);

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_count != 2'd2 || i_pop))
        else $error("word pushed into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_count != 2'd0))
        else $error("word popped from empty queue");

endmodule

`default_nettype wire

// File: hdl/b2a_back.sv
`timescale 1ns / 1ps
`default_nettype none

module b2a_back (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire b2a_pkg::t_entry               i_entry,
    input  wire b2a_pkg::t_fifo_stat           i_stat,
    output logic                               o_pop,
    output logic                               o_valid,
    output logic [b2a_pkg::CHAR_W-1:0]         o_char_code,
    output logic                               o_last
);

    localparam int CW = b2a_pkg::CNT_W;

    logic [CW-1:0]              r_left, n_left;
    logic [CW-1:0]              r_cnt, n_cnt;
    logic                       r_hex, n_hex;
    b2a_pkg::t_digits           r_digits, n_digits;
    logic                       r_valid, n_valid;
    logic [b2a_pkg::CHAR_W-1:0] r_char, n_char;
    logic                       r_last, n_last;

    logic [CW-1:0] w_idx;

    always_comb begin
        w_idx   = r_left - CW'(1);
        n_valid = (r_left != '0);
        n_last  = (r_left == CW'(1));
        if (r_hex && r_left == CW'(r_cnt + CW'(2))) begin
            n_char = b2a_pkg::CHAR_ZERO;
        end else if (r_hex && r_left == CW'(r_cnt + CW'(1))) begin
            n_char = b2a_pkg::CHAR_X;
        end else begin
            n_char = b2a_pkg::nib_to_char(r_digits[w_idx]);
        end

        // next job loads while the last char of the current one goes out
        o_pop    = !i_stat.empty && (r_left <= CW'(1));
        n_left   = r_left;
        n_cnt    = r_cnt;
        n_hex    = r_hex;
        n_digits = r_digits;
        if (o_pop) begin
            n_cnt    = i_entry.cnt;
            n_hex    = i_entry.hex;
            n_digits = i_entry.digits;
            n_left   = i_entry.hex ? CW'(i_entry.cnt + CW'(2)) : i_entry.cnt;
        end else if (r_left != '0) begin
            n_left = w_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left  <= '0;
            r_valid <= 1'b0;
        end else begin
            r_left  <= n_left;
            r_valid <= n_valid;
        end
        r_cnt    <= n_cnt;
        r_hex    <= n_hex;
        r_digits <= n_digits;
        r_char   <= n_char;
        r_last   <= n_last;
    end

    assign o_valid     = r_valid;
    assign o_char_code = r_char;
    assign o_last      = r_last;

    a_left_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_left <= CW'(b2a_pkg::DIG_MAX + 2))
        else $error("char count out of range");

    a_load_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_left > CW'(1)) |-> !o_pop)
        else $error("new word loaded mid text");

endmodule

`default_nettype wire

// File: hdl/binary_to_ascii_hex_decimal.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake               Payload
// input     in         start & !busy           i_func, i_value
// result    out        o_valid (per char)      o_char_code, o_last
//
// Hex word: front busy from the cycle after accept; the first char strobe
// follows the push state, the queue and the back-end char register, then
// 2 + ceil(VALUE_WIDTH/4) chars, one per cycle.
// Decimal word: shift-add-3 (one bit per cycle), then a push state in the
// front; the first char follows the queue and back-end char register, then
// 1 to 20 chars. The front takes a new word only once back in idle, after its
// loop and push state, and waits in its push state while the queue is full.
// Reset is synchronous, active low; it clears control state only.
// The receiver cannot stall: chars leave one per cycle from the back end.

module binary_to_ascii_hex_decimal #(
    parameter int VALUE_WIDTH = 64
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            start,
    output logic                                 busy,
    input  wire logic                            i_func,
    input  wire logic [b2a_pkg::FIELD_W-1:0]     i_value,
    output logic                                 o_valid,
    output logic [b2a_pkg::CHAR_W-1:0]           o_char_code,
    output logic                                 o_last
);

    logic                push;
    logic                pop;
    b2a_pkg::t_entry     front_entry;
    b2a_pkg::t_entry     back_entry;
    b2a_pkg::t_fifo_stat fifo_stat;

    // Front: takes a word, runs the binary-to-BCD loop for decimal, or just
    // splits into nibbles for hex; for decimal it then counts significant digits.
    b2a_front #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_func  (i_func),
        .i_value (i_value[VALUE_WIDTH-1:0]),
        .o_busy  (busy),
        .o_push  (push),
        .o_entry (front_entry),
        .i_stat  (fifo_stat)
    );

    // Two-deep queue decouples conversion from char output.
    b2a_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (front_entry),
        .i_pop   (pop),
        .o_entry (back_entry),
        .o_stat  (fifo_stat)
    );

    // Back: prefix (hex only), then digits MSD first, last flag on final char.
    b2a_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_entry     (back_entry),
        .i_stat      (fifo_stat),
        .o_pop       (pop),
        .o_valid     (o_valid),
        .o_char_code (o_char_code),
        .o_last      (o_last)
    );

endmodule

`default_nettype wire
